// File: sv/tlca_pkg.sv
// Shared constants, payload structs and walk status type for the tree LCA unit.
// No dependencies.
`default_nettype none

package tlca_pkg;

  localparam int NODE_W  = 10;
  localparam int CMD_W   = 2;
  localparam int PATH_W  = 11;
  localparam int DEPTH_W = 10;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_REROOT = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
    logic [NODE_W-1:0] third_node;
  } tlca_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor_node;
    logic [PATH_W-1:0] path_length;
  } tlca_out_t;

  typedef struct packed {
    logic [NODE_W-1:0] root_node;
  } tlca_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } walk_stat_t;

endpackage

`default_nettype wire

// File: sv/tlca_chan_if.sv
// Valid/ready channel with a typed payload.
// No dependencies; the payload type is set where the channel is instantiated.
`default_nettype none

interface tlca_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/tlca_tables.sv
// Depth table and ancestor table, each one write and one registered read port.
// Depends on tlca_pkg.
`default_nettype none

module tlca_tables import tlca_pkg::*; #(
  parameter int MAX_NODES  = 1024,
  parameter int LOG_LEVELS = 10,
  localparam int NW = $clog2(MAX_NODES),
  localparam int LW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1,
  localparam int ENTRIES = MAX_NODES * LOG_LEVELS,
  localparam int AW = $clog2(ENTRIES)
) (
  input  wire logic               clk_i,
  input  wire logic [NW-1:0]      dep_raddr_i,
  output logic      [DEPTH_W-1:0] dep_rdata_o,
  input  wire logic               dep_we_i,
  input  wire logic [NW-1:0]      dep_waddr_i,
  input  wire logic [DEPTH_W-1:0] dep_wdata_i,
  input  wire logic [NW-1:0]      anc_rnode_i,
  input  wire logic [LW-1:0]      anc_rlvl_i,
  output logic      [NW-1:0]      anc_rdata_o,
  input  wire logic               anc_we_i,
  input  wire logic [NW-1:0]      anc_wnode_i,
  input  wire logic [LW-1:0]      anc_wlvl_i,
  input  wire logic [NW-1:0]      anc_wdata_i
);

  logic [DEPTH_W-1:0] dep_mem_q [MAX_NODES];
  logic [NW-1:0]      anc_mem_q [ENTRIES];
  logic [DEPTH_W-1:0] dep_rdata_q;
  logic [NW-1:0]      anc_rdata_q;
  logic [AW-1:0]      anc_raddr;
  logic [AW-1:0]      anc_waddr;

  function automatic logic [AW-1:0] anc_addr(logic [NW-1:0] node, logic [LW-1:0] lvl);
    return AW'(node) * AW'(LOG_LEVELS) + AW'(lvl);
  endfunction

  assign anc_raddr = anc_addr(anc_rnode_i, anc_rlvl_i);
  assign anc_waddr = anc_addr(anc_wnode_i, anc_wlvl_i);

  always_ff @(posedge clk_i) begin
    if (dep_we_i) begin
      dep_mem_q[dep_waddr_i] <= dep_wdata_i;
    end
    dep_rdata_q <= dep_mem_q[dep_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (anc_we_i) begin
      anc_mem_q[anc_waddr] <= anc_wdata_i;
    end
    anc_rdata_q <= anc_mem_q[anc_raddr];
  end

  assign dep_rdata_o = dep_rdata_q;
  assign anc_rdata_o = anc_rdata_q;

endmodule

`default_nettype wire

// File: sv/tlca_walk.sv
// Binary-lifting LCA walker: levels two nodes, then climbs both from the top level down.
// Drives the read ports of the tables; depends on tlca_pkg.
`default_nettype none

module tlca_walk import tlca_pkg::*; #(
  parameter int MAX_NODES  = 1024,
  parameter int LOG_LEVELS = 10,
  localparam int NW = $clog2(MAX_NODES),
  localparam int LW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1,
  localparam int CW = $clog2(LOG_LEVELS + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [NW-1:0]      x_i,
  input  wire logic [NW-1:0]      y_i,
  input  wire logic [DEPTH_W-1:0] dep_rdata_i,
  input  wire logic [NW-1:0]      anc_rdata_i,
  output logic      [NW-1:0]      dep_raddr_o,
  output logic      [NW-1:0]      anc_rnode_o,
  output logic      [LW-1:0]      anc_rlvl_o,
  output walk_stat_t              stat_o,
  output logic      [NW-1:0]      res_o,
  output logic      [DEPTH_W-1:0] res_depth_o,
  output logic      [DEPTH_W-1:0] x_depth_o,
  output logic      [DEPTH_W-1:0] y_depth_o
);

  localparam logic [3:0] W_IDLE  = 4'd0;
  localparam logic [3:0] W_RDX   = 4'd1;
  localparam logic [3:0] W_RDY   = 4'd2;
  localparam logic [3:0] W_DIFF  = 4'd3;
  localparam logic [3:0] W_LIFT  = 4'd4;
  localparam logic [3:0] W_LIFTW = 4'd5;
  localparam logic [3:0] W_EQ    = 4'd6;
  localparam logic [3:0] W_UPA   = 4'd7;
  localparam logic [3:0] W_UPB   = 4'd8;
  localparam logic [3:0] W_UPC   = 4'd9;
  localparam logic [3:0] W_PAR   = 4'd10;
  localparam logic [3:0] W_PARW  = 4'd11;
  localparam logic [3:0] W_RDR   = 4'd12;
  localparam logic [3:0] W_FIN   = 4'd13;

  logic [3:0]         state_q, state_d;
  logic               done_q;
  logic [NW-1:0]      a_q, b_q, ua_q, res_q;
  logic [DEPTH_W-1:0] dx_q, dy_q, diff_q, dres_q;
  logic [CW-1:0]      lvl_q;
  logic               lift_end;
  logic               top_lvl;

  assign lift_end = (lvl_q == CW'(LOG_LEVELS)) || (diff_q == '0);
  assign top_lvl  = (lvl_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      W_IDLE:  if (start_i) state_d = W_RDX;
      W_RDX:   state_d = W_RDY;
      W_RDY:   state_d = W_DIFF;
      W_DIFF:  state_d = W_LIFT;
      W_LIFT: begin
        if (lift_end) begin
          state_d = W_EQ;
        end else if (diff_q[0]) begin
          state_d = W_LIFTW;
        end
      end
      W_LIFTW: state_d = W_LIFT;
      W_EQ:    state_d = (a_q == b_q) ? W_RDR : W_UPA;
      W_UPA:   state_d = W_UPB;
      W_UPB:   state_d = W_UPC;
      W_UPC:   state_d = top_lvl ? W_PAR : W_UPA;
      W_PAR:   state_d = W_PARW;
      W_PARW:  state_d = W_RDR;
      W_RDR:   state_d = W_FIN;
      W_FIN:   state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == W_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      W_IDLE: begin
        a_q <= x_i;
        b_q <= y_i;
      end
      W_RDY:  dx_q <= dep_rdata_i;
      W_DIFF: begin
        dy_q  <= dep_rdata_i;
        lvl_q <= '0;
        if (dx_q < dep_rdata_i) begin
          a_q    <= b_q;
          b_q    <= a_q;
          diff_q <= dep_rdata_i - dx_q;
        end else begin
          diff_q <= dx_q - dep_rdata_i;
        end
      end
      W_LIFT: begin
        if (!lift_end && !diff_q[0]) begin
          diff_q <= diff_q >> 1;
          lvl_q  <= lvl_q + CW'(1);
        end
      end
      W_LIFTW: begin
        a_q    <= anc_rdata_i;
        diff_q <= diff_q >> 1;
        lvl_q  <= lvl_q + CW'(1);
      end
      W_EQ: begin
        res_q <= a_q;
        lvl_q <= CW'(LOG_LEVELS - 1);
      end
      W_UPB:  ua_q <= anc_rdata_i;
      W_UPC: begin
        if (ua_q != anc_rdata_i) begin
          a_q <= ua_q;
          b_q <= anc_rdata_i;
        end
        if (!top_lvl) lvl_q <= lvl_q - CW'(1);
      end
      W_PARW: res_q  <= anc_rdata_i;
      W_FIN:  dres_q <= dep_rdata_i;
      default: ;
    endcase
  end

  always_comb begin
    case (state_q)
      W_RDY:   dep_raddr_o = b_q;
      W_RDR:   dep_raddr_o = res_q;
      default: dep_raddr_o = a_q;
    endcase
  end

  assign anc_rnode_o = (state_q == W_UPB) ? b_q : a_q;
  assign anc_rlvl_o  = (state_q == W_PAR) ? '0 : lvl_q[LW-1:0];

  assign stat_o.busy = (state_q != W_IDLE);
  assign stat_o.done = done_q;
  assign res_o       = res_q;
  assign res_depth_o = dres_q;
  assign x_depth_o   = dx_q;
  assign y_depth_o   = dy_q;

endmodule

`default_nettype wire

// File: sv/tree_lca_binary_lifting_unit.sv
// Tree LCA unit: ordered node loads build depth and binary-lifting tables; queries
// return the lowest common ancestor and distance. Depends on tlca_pkg, tlca_chan_if,
// tlca_tables and tlca_walk.
//
//   Channel  Dir  Payload                                       Transaction
//   in_i     in   cmd, first_node, second_node, third_node      valid & ready
//   out_o    out  ancestor_node, path_length                    valid & ready
//   cfg_i    in   root_node                                     valid & ready (always ready)
//
// One item at a time: a new item is taken only in idle, once the last one is through.
// A rerooted query runs three walks, a plain query one.
// Each lifting step waits on the one read port of the ancestor table.
// Reset clears the control and root_node only; tables hold garbage until loaded.
// A result waits in the output register; the next item is taken meanwhile and
// only its own result stalls behind a full output register.
`default_nettype none

module tree_lca_binary_lifting_unit import tlca_pkg::*; #(
  parameter int MAX_NODES  = 1024,
  parameter int LOG_LEVELS = 10
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tlca_chan_if.sink   in_i,
  tlca_chan_if.source out_o,
  tlca_chan_if.sink   cfg_i
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int LW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
  localparam int CW = $clog2(LOG_LEVELS + 1);
  localparam int RECIP_SH = 20;
  localparam int RECIP = ((1 << RECIP_SH) + MAX_NODES - 1) / MAX_NODES;

  localparam int IX_A = 0;
  localparam int IX_B = 1;
  localparam int IX_C = 2;
  localparam int IX_R = 3;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED1 = 4'd1;
  localparam logic [3:0] S_RED2 = 4'd2;
  localparam logic [3:0] S_LD0  = 4'd3;
  localparam logic [3:0] S_LD1  = 4'd4;
  localparam logic [3:0] S_LDW  = 4'd5;
  localparam logic [3:0] S_LDN  = 4'd6;
  localparam logic [3:0] S_Q1   = 4'd7;
  localparam logic [3:0] S_Q1W  = 4'd8;
  localparam logic [3:0] S_Q2   = 4'd9;
  localparam logic [3:0] S_Q2W  = 4'd10;
  localparam logic [3:0] S_Q3   = 4'd11;
  localparam logic [3:0] S_Q3W  = 4'd12;
  localparam logic [3:0] S_EMIT = 4'd13;

  logic [3:0]         state_q, state_d;
  logic [NODE_W-1:0]  root_q;
  logic               out_valid_q;
  tlca_out_t          out_q;

  logic [CMD_W-1:0]   cmd_q;
  logic [NODE_W-1:0]  raw_q [4];
  logic [NODE_W-1:0]  quo_q [4];
  logic [NW-1:0]      idx_q [4];
  logic [CW-1:0]      lvl_q;
  logic [NW-1:0]      walk_q;
  logic [DEPTH_W-1:0] dep_q;
  logic [NW-1:0]      base_q, c_q, anc_q;
  logic [DEPTH_W-1:0] dc_q;
  logic [PATH_W-1:0]  dist_q;

  logic               dep_we, anc_we;
  logic [NW-1:0]      dep_waddr, anc_wnode, anc_wdata;
  logic [DEPTH_W-1:0] dep_wdata;
  logic [LW-1:0]      anc_wlvl;
  logic [NW-1:0]      dep_raddr, anc_rnode;
  logic [LW-1:0]      anc_rlvl;
  logic [DEPTH_W-1:0] dep_rdata;
  logic [NW-1:0]      anc_rdata;

  logic               walk_start;
  logic [NW-1:0]      walk_x, walk_y;
  walk_stat_t         walk_stat;
  logic [NW-1:0]      w_dep_raddr, w_anc_rnode, w_res;
  logic [LW-1:0]      w_anc_rlvl;
  logic [DEPTH_W-1:0] w_res_depth, w_x_depth, w_y_depth;

  logic               lvl_end;
  logic               emit_go;
  logic [11:0]        dsum, dtwice;
  logic [PATH_W-1:0]  span;

  assign lvl_end = (lvl_q == CW'(LOG_LEVELS));
  assign emit_go = !out_valid_q || out_o.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_i.valid) state_d = S_RED1;
      S_RED1: state_d = S_RED2;
      S_RED2: begin
        unique case (cmd_q) inside
          CMD_LOAD:               state_d = S_LD0;
          CMD_QUERY, CMD_REROOT:  state_d = S_Q1;
          default:                state_d = S_IDLE;
        endcase
      end
      S_LD0:  state_d = (idx_q[IX_A] == idx_q[IX_R]) ? S_LDW : S_LD1;
      S_LD1:  state_d = S_LDW;
      S_LDW: begin
        if (lvl_end) begin
          state_d = S_IDLE;
        end else if (walk_q != idx_q[IX_R]) begin
          state_d = S_LDN;
        end
      end
      S_LDN:  state_d = S_LDW;
      S_Q1:   state_d = S_Q1W;
      S_Q1W:  if (walk_stat.done) state_d = (cmd_q == CMD_QUERY) ? S_EMIT : S_Q2;
      S_Q2:   state_d = S_Q2W;
      S_Q2W:  if (walk_stat.done) state_d = S_Q3;
      S_Q3:   state_d = S_Q3W;
      S_Q3W:  if (walk_stat.done) state_d = S_EMIT;
      S_EMIT: if (emit_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) root_q <= cfg_i.data.root_node;
      if (state_q == S_EMIT && emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign dsum   = 12'(w_x_depth) + 12'(w_y_depth);
  assign dtwice = {1'b0, w_res_depth, 1'b0};
  assign span   = (dsum >= dtwice) ? PATH_W'(dsum - dtwice) : '0;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q       <= in_i.data.cmd;
        raw_q[IX_A] <= in_i.data.first_node;
        raw_q[IX_B] <= in_i.data.second_node;
        raw_q[IX_C] <= in_i.data.third_node;
        raw_q[IX_R] <= root_q;
      end
      S_RED1: begin
        for (int k = 0; k < 4; k++) begin
          quo_q[k] <= NODE_W'((32'(raw_q[k]) * 32'(RECIP)) >> RECIP_SH);
        end
      end
      S_RED2: begin
        for (int k = 0; k < 4; k++) begin
          idx_q[k] <= NW'(32'(raw_q[k]) - 32'(quo_q[k]) * 32'(MAX_NODES));
        end
      end
      S_LD0: begin
        lvl_q  <= '0;
        walk_q <= (idx_q[IX_A] == idx_q[IX_R]) ? idx_q[IX_R] : idx_q[IX_C];
        dep_q  <= '0;
      end
      S_LD1: dep_q <= (dep_rdata == DEPTH_MAX) ? DEPTH_MAX : dep_rdata + DEPTH_W'(1);
      S_LDW: if (!lvl_end && walk_q == idx_q[IX_R]) lvl_q <= lvl_q + CW'(1);
      S_LDN: begin
        walk_q <= anc_rdata;
        lvl_q  <= lvl_q + CW'(1);
      end
      S_Q1W: begin
        base_q <= w_res;
        anc_q  <= w_res;
        dist_q <= span;
      end
      S_Q2W: begin
        c_q  <= w_res;
        dc_q <= w_res_depth;
      end
      S_Q3W: begin
        if (c_q == w_res) begin
          anc_q <= base_q;
        end else begin
          anc_q <= (dc_q < w_res_depth) ? w_res : c_q;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_q.ancestor_node <= NODE_W'(anc_q);
          out_q.path_length   <= dist_q;
        end
      end
      default: ;
    endcase
  end

  // table writes come from the load sequence only
  always_comb begin
    dep_we    = 1'b0;
    dep_waddr = idx_q[IX_A];
    dep_wdata = dep_q;
    anc_we    = 1'b0;
    anc_wnode = idx_q[IX_A];
    anc_wlvl  = lvl_q[LW-1:0];
    anc_wdata = walk_q;
    case (state_q)
      S_LDW: begin
        if (lvl_end) begin
          dep_we = 1'b1;
        end else if (walk_q == idx_q[IX_R]) begin
          anc_we = 1'b1;
        end
      end
      S_LDN: anc_we = 1'b1;
      default: ;
    endcase
  end

  assign dep_raddr = walk_stat.busy ? w_dep_raddr : idx_q[IX_C];
  assign anc_rnode = walk_stat.busy ? w_anc_rnode : walk_q;
  assign anc_rlvl  = walk_stat.busy ? w_anc_rlvl  : lvl_q[LW-1:0];

  assign walk_start = (state_q == S_Q1) || (state_q == S_Q2) || (state_q == S_Q3);
  assign walk_x     = (state_q == S_Q3) ? idx_q[IX_B] : idx_q[IX_A];
  assign walk_y     = (state_q == S_Q1) ? idx_q[IX_B] : idx_q[IX_C];

  tlca_tables #(
    .MAX_NODES  (MAX_NODES),
    .LOG_LEVELS (LOG_LEVELS)
  ) u_tables (
    .clk_i       (clk_i),
    .dep_raddr_i (dep_raddr),
    .dep_rdata_o (dep_rdata),
    .dep_we_i    (dep_we),
    .dep_waddr_i (dep_waddr),
    .dep_wdata_i (dep_wdata),
    .anc_rnode_i (anc_rnode),
    .anc_rlvl_i  (anc_rlvl),
    .anc_rdata_o (anc_rdata),
    .anc_we_i    (anc_we),
    .anc_wnode_i (anc_wnode),
    .anc_wlvl_i  (anc_wlvl),
    .anc_wdata_i (anc_wdata)
  );

  tlca_walk #(
    .MAX_NODES  (MAX_NODES),
    .LOG_LEVELS (LOG_LEVELS)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (walk_start),
    .x_i         (walk_x),
    .y_i         (walk_y),
    .dep_rdata_i (dep_rdata),
    .anc_rdata_i (anc_rdata),
    .dep_raddr_o (w_dep_raddr),
    .anc_rnode_o (w_anc_rnode),
    .anc_rlvl_o  (w_anc_rlvl),
    .stat_o      (walk_stat),
    .res_o       (w_res),
    .res_depth_o (w_res_depth),
    .x_depth_o   (w_x_depth),
    .y_depth_o   (w_y_depth)
  );

  a_accept_walk_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !walk_stat.busy)
    else $error("transaction accepted while walker busy");

  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_stat.busy |-> !(dep_we || anc_we))
    else $error("table write during walk");

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_stat.done |-> (state_q == S_Q1W || state_q == S_Q2W || state_q == S_Q3W))
    else $error("walk done with no query waiting");

  a_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LDN) |-> (lvl_q < CW'(LOG_LEVELS)))
    else $error("ancestor fill beyond top level");

endmodule

`default_nettype wire
